// ===== hw/rtl/tf256_pkg.sv =====
// Shared types, constants and helper functions of the Threefish-256 unit
`timescale 1ns / 1ps
package tf256_pkg;

  localparam int Words   = 4;
  localparam int Rounds  = 72;
  localparam int Subkeys = 19;
  localparam logic [63:0] Parity = 64'h1BD11BDAA9FC1A22;

  localparam int RotEven [8] = '{14, 52, 23, 5, 25, 46, 58, 32};
  localparam int RotOdd  [8] = '{16, 57, 40, 37, 33, 12, 22, 32};

  localparam logic [2:0] RegKey0   = 3'd0;
  localparam logic [2:0] RegKey1   = 3'd1;
  localparam logic [2:0] RegKey2   = 3'd2;
  localparam logic [2:0] RegKey3   = 3'd3;
  localparam logic [2:0] RegTweak0 = 3'd4;
  localparam logic [2:0] RegTweak1 = 3'd5;

  typedef struct packed {
    logic        action;
    logic [63:0] block_in_0;
    logic [63:0] block_in_1;
    logic [63:0] block_in_2;
    logic [63:0] block_in_3;
  } tf_in_t;

  typedef struct packed {
    logic [63:0] block_out_0;
    logic [63:0] block_out_1;
    logic [63:0] block_out_2;
    logic [63:0] block_out_3;
  } tf_out_t;

  typedef logic [Words-1:0][63:0] tf_words_t;

  typedef struct packed {
    logic      dec;
    tf_words_t w;
  } tf_stage_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] rotr64(input logic [63:0] x, input int r);
    return (x >> r) | (x << (64 - r));
  endfunction

  function automatic tf_words_t subkey(input tf_words_t k, input logic [1:0][63:0] t,
                                       input int s);
    logic [4:0][63:0] ke;
    logic [2:0][63:0] te;
    tf_words_t        sk;
    ke[3:0] = k;
    ke[4]   = k[0] ^ k[1] ^ k[2] ^ k[3] ^ Parity;
    te[1:0] = t;
    te[2]   = t[0] ^ t[1];
    sk[0]   = ke[s % 5];
    sk[1]   = ke[(s + 1) % 5] + te[s % 3];
    sk[2]   = ke[(s + 2) % 5] + te[(s + 1) % 3];
    sk[3]   = ke[(s + 3) % 5] + 64'(s);
    return sk;
  endfunction

endpackage

// ===== hw/rtl/threefish256_block_cipher_unit.sv =====
// Pipeline: entry key add (encryption), 72 rounds, exit key subtract (decryption), each registered.
// Throughput: one block per cycle unless a waiting result beat holds the pipeline; one register stage per round.
// The whole pipeline holds while a result beat waits for out_ready.
// Subkeys are registered from the key and tweak registers, so a register write reaches them after the key register.
// Reset clears all stage valid bits and the key and tweak registers to zero.
`timescale 1ns / 1ps
module threefish256_block_cipher_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tf256_pkg::tf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tf256_pkg::tf_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import tf256_pkg::*;

  localparam int Stages = Rounds + 2;

  tf_words_t        key;
  logic [1:0][63:0] tweak;
  tf_words_t        sk [Subkeys];
  logic             en;
  logic             vld [Stages];
  tf_stage_t        stg [Stages];
  tf_words_t        win;

  assign cfg_ready = 1'b1;
  assign en        = !vld[Stages-1] || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      key   <= '0;
      tweak <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegKey0:   key[0]   <= cfg_data;
        RegKey1:   key[1]   <= cfg_data;
        RegKey2:   key[2]   <= cfg_data;
        RegKey3:   key[3]   <= cfg_data;
        RegTweak0: tweak[0] <= cfg_data;
        RegTweak1: tweak[1] <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < Subkeys; s++) sk[s] <= subkey(key, tweak, s);
  end

  assign win = {in_data.block_in_3, in_data.block_in_2, in_data.block_in_1,
                in_data.block_in_0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0].dec <= in_data.action;
      for (int i = 0; i < Words; i++) begin
        stg[0].w[i] <= in_data.action ? win[i] : win[i] + sk[0][i];
      end
    end
  end

  for (genvar g = 0; g < Rounds; g++) begin : g_round
    tf256_round #(.RoundIdx(g)) u_round (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_in (vld[g]),
      .stg_in (stg[g]),
      .sk_enc (sk[(g + 1) / 4]),
      .sk_dec (sk[(Rounds - g) / 4]),
      .vld    (vld[g+1]),
      .stg    (stg[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[Stages-1] <= 1'b0;
    end else if (en) begin
      vld[Stages-1] <= vld[Stages-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[Stages-1].dec <= stg[Stages-2].dec;
      for (int i = 0; i < Words; i++) begin
        stg[Stages-1].w[i] <= stg[Stages-2].dec ? stg[Stages-2].w[i] - sk[0][i]
                                                : stg[Stages-2].w[i];
      end
    end
  end

  assign out_valid            = vld[Stages-1];
  assign out_data.block_out_0 = stg[Stages-1].w[0];
  assign out_data.block_out_1 = stg[Stages-1].w[1];
  assign out_data.block_out_2 = stg[Stages-1].w[2];
  assign out_data.block_out_3 = stg[Stages-1].w[3];

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted beat did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld[Stages/2]) && $stable(stg[Stages/2]))
    else $error("pipeline moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

// ===== hw/rtl/tf256_round.sv =====
// One registered round of the cipher, forward or inverse per beat
`timescale 1ns / 1ps
module tf256_round #(
  parameter int RoundIdx = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  tf256_pkg::tf_stage_t stg_in,
  input  tf256_pkg::tf_words_t sk_enc,
  input  tf256_pkg::tf_words_t sk_dec,
  output logic                 vld,
  output tf256_pkg::tf_stage_t stg
);
  import tf256_pkg::*;

  localparam int  DecIdx = Rounds - 1 - RoundIdx;
  localparam bit  EncAdd = (RoundIdx % 4) == 3;
  localparam bit  DecSub = (DecIdx % 4) == 3;

  tf_words_t v, a, e, u, d;

  always_comb begin
    v    = stg_in.w;
    a[0] = v[0] + v[1];
    a[1] = rotl64(v[1], RotEven[RoundIdx % 8]) ^ a[0];
    a[2] = v[2] + v[3];
    a[3] = rotl64(v[3], RotOdd[RoundIdx % 8]) ^ a[2];
    e    = {a[1], a[2], a[3], a[0]};
    if (EncAdd) begin
      for (int i = 0; i < Words; i++) e[i] = e[i] + sk_enc[i];
    end
    u = v;
    if (DecSub) begin
      for (int i = 0; i < Words; i++) u[i] = v[i] - sk_dec[i];
    end
    d[1] = rotr64(u[3] ^ u[0], RotEven[DecIdx % 8]);
    d[0] = u[0] - d[1];
    d[3] = rotr64(u[1] ^ u[2], RotOdd[DecIdx % 8]);
    d[2] = u[2] - d[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg.dec <= stg_in.dec;
      stg.w   <= stg_in.dec ? d : e;
    end
  end

endmodule
